### hw/rtl/sia_pkg.sv
// Shared types, field widths and codes for the sample interval arbiter.
// Depends on nothing; every RTL file of the block imports it.
package sia_pkg;

    // Payload widths fixed by the interface.
    localparam int DATA_W       = 32;
    localparam int SESS_FIELD_W = 4;
    localparam int KIND_W       = 2;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 72;

    // A snapping distance at or above this limit is never taken.
    localparam logic [DATA_W-1:0] ERR_LIMIT = 32'h7fff_ffff;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_COUNT    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RANGE0_LOW     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RANGE0_HIGH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFAULT_PERIOD = 3'd7;

    // Request kinds carried on the slave-side tuser.
    localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEFAULT = 2'd2;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SNAP,
        ST_SCAN,
        ST_OUT
    } sia_state_t;

    // One session entry as held by a cell and passed along the ring.
    typedef struct packed {
        logic              present;
        logic [DATA_W-1:0] period;
    } entry_t;

    // Register index of the lower bound of range r.
    function automatic logic [CFG_ADDR_W-1:0] range_low_addr(input int r);
        range_low_addr = CFG_RANGE0_LOW + CFG_ADDR_W'(2 * r);
    endfunction

    // Register index of the upper bound of range r.
    function automatic logic [CFG_ADDR_W-1:0] range_high_addr(input int r);
        range_high_addr = CFG_RANGE0_HIGH + CFG_ADDR_W'(2 * r);
    endfunction

endpackage

### hw/rtl/sia_cell.sv
// One session entry of the arbiter's ring of cells.
// Depends on sia_pkg for the entry type.
module sia_cell
    import sia_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  logic   wr_en,
    input  entry_t wr_entry,
    input  entry_t nbr_entry,
    output entry_t entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // During a scan the entry moves on to the neighbour; otherwise it may be written.
    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = nbr_entry;
        end
        else if (wr_en)
        begin
            entry_next = wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

### hw/rtl/sia_snap.sv
// Snaps a requested interval to the configured ranges, one range per cycle.
// Depends on sia_pkg for widths and the distance limit.
module sia_snap
    import sia_pkg::*;
#(
    parameter int RANGES = 3,
    localparam int IDX_W = $clog2(RANGES + 1),
    localparam int RIDX_W = (RANGES > 1) ? $clog2(RANGES) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] value,
    input  logic [IDX_W-1:0]  range_used,
    input  logic [DATA_W-1:0] range_low [RANGES],
    input  logic [DATA_W-1:0] range_high [RANGES],
    output logic              done,
    output logic [DATA_W-1:0] result
);

    logic              busy_reg;
    logic              busy_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic [DATA_W-1:0] best_reg;
    logic [DATA_W-1:0] best_next;
    logic [DATA_W-1:0] best_err_reg;
    logic [DATA_W-1:0] best_err_next;

    logic              in_range;
    logic              below;
    logic              above;
    logic              more_ranges;
    logic [DATA_W-1:0] cur_low;
    logic [DATA_W-1:0] cur_high;
    logic [DATA_W-1:0] err;
    logic [DATA_W-1:0] bound;

    // Distance from the value to the range under test.
    always_comb
    begin
        more_ranges = idx_reg < range_used;
        cur_low     = range_low[idx_reg[RIDX_W-1:0]];
        cur_high    = range_high[idx_reg[RIDX_W-1:0]];
        below       = val_reg < cur_low;
        above       = val_reg > cur_high;
        in_range    = more_ranges && !below && !above;
        if (below)
        begin
            err   = cur_low - val_reg;
            bound = cur_low;
        end
        else
        begin
            err   = val_reg - cur_high;
            bound = cur_high;
        end
    end

    // A zero request, a hit inside a range or the end of the ranges finishes.
    assign done   = busy_reg && (val_reg == '0 || !more_ranges || in_range);
    assign result = (in_range && val_reg != '0) ? val_reg : best_reg;

    // Iteration over the ranges, keeping the nearest bound seen so far.
    always_comb
    begin
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        best_next     = best_reg;
        best_err_next = best_err_reg;
        if (start)
        begin
            busy_next     = 1'b1;
            idx_next      = '0;
            val_next      = value;
            best_next     = '0;
            best_err_next = ERR_LIMIT;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            idx_next = idx_reg + 1'b1;
            if (best_err_reg > err)
            begin
                best_err_next = err;
                best_next     = bound;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        best_reg     <= best_next;
        best_err_reg <= best_err_next;
    end

endmodule

### hw/rtl/sample_interval_arbiter_unit.sv
// Top level of the sample interval arbiter: sequencer, ring of session cells,
// configuration registers and output register. Depends on sia_pkg, sia_cell, sia_snap.
//
// Usage: a request word enters on the slave side (s_tvalid/s_tready), with the
// request kind on s_tuser and session and requested interval on s_tdata. Set
// and default requests snap the interval to the configured ranges and store it
// in the session's cell; remove requests clear the cell. The ring of SESSIONS
// cells then rotates once past the evaluator, one entry per cycle, to find the
// winning session and the applied interval. One result word leaves on the
// master side (m_tvalid/m_tready).
// A stored request passes snapping, a full rotation of the ring and the load of
// the output register before m_tvalid; a remove skips the snapping, and an
// ignored request goes straight to the output register. A new request is taken
// only once the sequencer is idle again, after the output register is loaded.
// Reset empties the session table, clears the applied interval and all
// configuration registers. A stalled receiver holds the result word in the
// output register; the next request is still taken and worked on, and its
// result waits until the register is free. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata while no request is in flight, a rule for the user
// that the block itself leaves unenforced.
module sample_interval_arbiter_unit
    import sia_pkg::*;
#(
    parameter int SESSIONS = 16,
    parameter int RANGES = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port.
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Request stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata from bit 0: session [3:0], requested_period [35:4], zero fill.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser from bit 0: kind [1:0].
    input  logic [KIND_W-1:0]     s_tuser,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: stored_period [31:0], has_winner [32],
    // winner_session [36:33], applied_period [68:37], period_changed [69], zero fill.
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int IDX_W  = $clog2(RANGES + 1);
    localparam int SIDX_W = $clog2(SESSIONS);

    // Configuration registers.
    logic [1:0]        range_count_reg;
    logic [DATA_W-1:0] range_low_reg [RANGES];
    logic [DATA_W-1:0] range_high_reg [RANGES];
    logic [DATA_W-1:0] default_reg;

    // Sequencer and evaluation state.
    sia_state_t              state_reg;
    sia_state_t              state_next;
    logic [SIDX_W-1:0]       scan_idx_reg;
    logic [DATA_W-1:0]       chosen_reg;
    logic [SIDX_W-1:0]       best_sess_reg;
    logic                    found_reg;
    logic [DATA_W-1:0]       current_reg;
    logic [SESS_FIELD_W-1:0] sess_reg;

    // Result waiting for the output register.
    logic [DATA_W-1:0]       res_stored_reg;
    logic                    res_has_win_reg;
    logic [SESS_FIELD_W-1:0] res_win_sess_reg;
    logic                    res_changed_reg;

    // Output register.
    logic                    out_valid_reg;
    logic [DATA_W-1:0]       out_stored_reg;
    logic                    out_has_win_reg;
    logic [SESS_FIELD_W-1:0] out_win_sess_reg;
    logic [DATA_W-1:0]       out_applied_reg;
    logic                    out_changed_reg;

    // Request fields.
    logic [SESS_FIELD_W-1:0] in_session;
    logic [DATA_W-1:0]       in_period;
    logic [KIND_W-1:0]       in_kind;
    logic                    accept;
    logic                    sess_ok;
    logic                    act_store;
    logic                    act_remove;

    // Sequencer outputs.
    logic                    snap_start;
    logic                    cell_wr;
    logic                    shift;
    logic                    load_out;

    // Datapath signals.
    logic [IDX_W-1:0]        range_used;
    logic [DATA_W-1:0]       snap_value;
    logic                    snap_done;
    logic [DATA_W-1:0]       snap_result;
    logic [SESS_FIELD_W-1:0] wr_session;
    entry_t                  wr_entry;
    entry_t                  cell_q [SESSIONS];
    entry_t                  head;
    logic                    scan_last;
    logic                    take;
    logic [DATA_W-1:0]       chosen_upd;
    logic [SIDX_W-1:0]       best_sess_upd;
    logic                    found_upd;
    logic [DATA_W-1:0]       win_val;

    // Request decoding.
    assign in_session = s_tdata[SESS_FIELD_W-1:0];
    assign in_period  = s_tdata[SESS_FIELD_W +: DATA_W];
    assign in_kind    = s_tuser;
    assign accept     = s_tvalid && s_tready;
    assign sess_ok    = 32'(in_session) < SESSIONS;
    assign act_store  = sess_ok && (in_kind == KIND_SET ||
                        (in_kind == KIND_DEFAULT && default_reg != '0));
    assign act_remove = sess_ok && in_kind == KIND_REMOVE;
    assign scan_last  = scan_idx_reg == SIDX_W'(SESSIONS - 1);

    // Configuration writes; bounds of ranges beyond RANGES are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_count_reg <= '0;
            default_reg     <= '0;
            for (int r = 0; r < RANGES; r++)
            begin
                range_low_reg[r]  <= '0;
                range_high_reg[r] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_RANGE_COUNT)
            begin
                range_count_reg <= cfg_wdata[1:0];
            end
            if (cfg_addr == CFG_DEFAULT_PERIOD)
            begin
                default_reg <= cfg_wdata;
            end
            for (int r = 0; r < RANGES; r++)
            begin
                if (cfg_addr == range_low_addr(r))
                begin
                    range_low_reg[r] <= cfg_wdata;
                end
                if (cfg_addr == range_high_addr(r))
                begin
                    range_high_reg[r] <= cfg_wdata;
                end
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (act_store)
                    begin
                        state_next = ST_SNAP;
                    end
                    else if (act_remove)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SNAP:
            begin
                if (snap_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready   = 1'b0;
        snap_start = 1'b0;
        cell_wr    = 1'b0;
        shift      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                snap_start = s_tvalid && act_store;
                cell_wr    = s_tvalid && act_remove;
            end
            ST_SNAP:
            begin
                cell_wr = snap_done;
            end
            ST_SCAN:
            begin
                shift = 1'b1;
            end
            ST_OUT:
            begin
                load_out = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Range snapping unit.
    assign range_used = (range_count_reg > 2'(RANGES)) ? IDX_W'(RANGES)
                                                        : IDX_W'(range_count_reg);
    assign snap_value = (in_kind == KIND_SET) ? in_period : default_reg;

    sia_snap #(
        .RANGES     (RANGES)
    ) u_snap (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (snap_start),
        .value      (snap_value),
        .range_used (range_used),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .done       (snap_done),
        .result     (snap_result)
    );

    // Ring of session cells; cell i takes cell i+1's entry on each shift.
    assign wr_session       = (state_reg == ST_IDLE) ? in_session : sess_reg;
    assign wr_entry.present = (state_reg == ST_SNAP);
    assign wr_entry.period  = (state_reg == ST_SNAP) ? snap_result : '0;

    for (genvar i = 0; i < SESSIONS; i++)
    begin : g_cell
        sia_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift),
            .wr_en     (cell_wr && 32'(wr_session) == i),
            .wr_entry  (wr_entry),
            .nbr_entry (cell_q[(i + 1) % SESSIONS]),
            .entry     (cell_q[i])
        );
    end

    assign head = cell_q[0];

    // Evaluator: least positive period, ties to lowest session; all zero to highest.
    always_comb
    begin
        take          = head.present &&
                        ((head.period != '0 && head.period < chosen_reg) || chosen_reg == '0);
        chosen_upd    = take ? head.period : chosen_reg;
        best_sess_upd = take ? scan_idx_reg : best_sess_reg;
        found_upd     = found_reg || head.present;
        win_val       = (chosen_upd == '0) ? default_reg : chosen_upd;
    end

    // Scan control and applied interval.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            chosen_reg    <= '0;
            best_sess_reg <= '0;
            found_reg     <= 1'b0;
            current_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SCAN && !scan_last)
            begin
                scan_idx_reg  <= scan_idx_reg + 1'b1;
                chosen_reg    <= chosen_upd;
                best_sess_reg <= best_sess_upd;
                found_reg     <= found_upd;
            end
            else
            begin
                scan_idx_reg  <= '0;
                chosen_reg    <= '0;
                best_sess_reg <= '0;
                found_reg     <= 1'b0;
            end
            if (state_reg == ST_SCAN && scan_last && found_upd)
            begin
                current_reg <= win_val;
            end
        end
    end

    // Result fields gathered while the request is worked on.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sess_reg         <= in_session;
            res_stored_reg   <= '0;
            res_has_win_reg  <= 1'b0;
            res_win_sess_reg <= '0;
            res_changed_reg  <= 1'b0;
        end
        if (state_reg == ST_SNAP && snap_done)
        begin
            res_stored_reg <= snap_result;
        end
        if (state_reg == ST_SCAN && scan_last)
        begin
            res_has_win_reg  <= found_upd;
            res_win_sess_reg <= found_upd ? SESS_FIELD_W'(best_sess_upd) : '0;
            res_changed_reg  <= found_upd && (win_val != current_reg);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_stored_reg   <= res_stored_reg;
            out_has_win_reg  <= res_has_win_reg;
            out_win_sess_reg <= res_win_sess_reg;
            out_applied_reg  <= current_reg;
            out_changed_reg  <= res_changed_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_changed_reg, out_applied_reg, out_win_sess_reg,
                       out_has_win_reg, out_stored_reg};

    // The snapping unit finishes only while the sequencer waits for it.
    a_snap_done_in_snap : assert property (@(posedge clk) disable iff (!rst_n)
        snap_done |-> state_reg == ST_SNAP)
        else $error("snap unit finished outside the snap state");

    // A full rotation of the ring always ends in the output state.
    a_scan_to_out : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_last) |=> state_reg == ST_OUT)
        else $error("ring scan did not hand over to the output state");

    // The ring is back in place whenever no scan is running.
    a_scan_idx_home : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_SCAN |-> scan_idx_reg == '0)
        else $error("scan index left off home position");

    // Without a winner the applied interval cannot have changed.
    a_no_win_no_change : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_has_win_reg) |-> !out_changed_reg)
        else $error("interval change reported without a winner");

endmodule

### tb/sv/sia_checker.sv
// Checker for the sample interval arbiter: watches the configuration port and both
// word streams, predicts each result word and compares it field by field.
// Depends on sia_pkg for widths, register indexes and request kinds.
`timescale 1ns / 100ps

module sia_checker
    import sia_pkg::*;
#(
    parameter int SESSIONS = 16,
    parameter int RANGES = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // s_tdata from bit 0: session [3:0], requested_period [35:4], zero fill.
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // s_tuser from bit 0: kind [1:0].
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata from bit 0: stored_period [31:0], has_winner [32],
    // winner_session [36:33], applied_period [68:37], period_changed [69], zero fill.
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    errors,
    output int                    outstanding
);

    // One result word, unpacked into its fields.
    typedef struct {
        logic [DATA_W-1:0]       stored;
        logic                    has_winner;
        logic [SESS_FIELD_W-1:0] winner;
        logic [DATA_W-1:0]       applied;
        logic                    changed;
    } interval_result_t;

    // Predicted configuration.
    logic [1:0]        range_count_q;
    logic [DATA_W-1:0] range_low_q [RANGES];
    logic [DATA_W-1:0] range_high_q [RANGES];
    logic [DATA_W-1:0] default_period_q;

    // Predicted session table and applied interval.
    logic              entry_present_q [SESSIONS];
    logic [DATA_W-1:0] entry_period_q [SESSIONS];
    logic [DATA_W-1:0] applied_period_q;

    // Result words still owed by the block, oldest first.
    interval_result_t pending_results [$];

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    // Snaps a requested interval to the configured ranges.
    function automatic logic [DATA_W-1:0] snap_interval(input logic [DATA_W-1:0] req);
        logic [DATA_W-1:0] best;
        logic [DATA_W-1:0] best_gap;
        logic [DATA_W-1:0] gap;
        logic [DATA_W-1:0] edge_val;
        int                used;
        best = '0;
        best_gap = ERR_LIMIT;
        if (req == '0)
            return '0;
        used = (int'(range_count_q) > RANGES) ? RANGES : int'(range_count_q);
        for (int r = 0; r < used; r++)
        begin
            if (req < range_low_q[r])
            begin
                gap = range_low_q[r] - req;
                edge_val = range_low_q[r];
            end
            else if (req > range_high_q[r])
            begin
                gap = req - range_high_q[r];
                edge_val = range_high_q[r];
            end
            else
                return req;
            // Strict compare keeps the earlier range on equal distance.
            if (best_gap > gap)
            begin
                best_gap = gap;
                best = edge_val;
            end
        end
        return best;
    endfunction

    // Applies one request to the predicted table and works out its result word.
    function automatic interval_result_t work_out_request(input logic [KIND_W-1:0] kind,
            input logic [SESS_FIELD_W-1:0] sess, input logic [DATA_W-1:0] req);
        interval_result_t  res;
        logic [DATA_W-1:0] before_val;
        logic [DATA_W-1:0] chosen;
        int                chosen_sess;
        logic              acted;
        logic              found;
        before_val = applied_period_q;
        res.stored = '0;
        res.has_winner = 1'b0;
        res.winner = '0;
        acted = 1'b0;
        if (int'(sess) < SESSIONS)
        begin
            if (kind == KIND_SET || (kind == KIND_DEFAULT && default_period_q != '0))
            begin
                res.stored = snap_interval(kind == KIND_SET ? req : default_period_q);
                entry_present_q[sess] = 1'b1;
                entry_period_q[sess] = res.stored;
                acted = 1'b1;
            end
            else if (kind == KIND_REMOVE)
            begin
                entry_present_q[sess] = 1'b0;
                entry_period_q[sess] = '0;
                acted = 1'b1;
            end
        end
        // Smallest positive entry wins; all-zero tables fall to the highest session.
        if (acted)
        begin
            found = 1'b0;
            chosen = '0;
            chosen_sess = 0;
            for (int s = 0; s < SESSIONS; s++)
            begin
                if (entry_present_q[s])
                begin
                    if ((entry_period_q[s] > 0 && entry_period_q[s] < chosen) || chosen == 0)
                    begin
                        chosen = entry_period_q[s];
                        chosen_sess = s;
                    end
                    found = 1'b1;
                end
            end
            if (chosen == '0)
                chosen = default_period_q;
            if (found)
            begin
                applied_period_q = chosen;
                res.has_winner = 1'b1;
                res.winner = chosen_sess[SESS_FIELD_W-1:0];
            end
        end
        res.applied = applied_period_q;
        res.changed = (applied_period_q != before_val);
        return res;
    endfunction

    // Compares one accepted result word with the oldest prediction.
    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        interval_result_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result word %0h with no request waiting", word));
            return;
        end
        want = pending_results.pop_front();
        check_field("stored_period", want.stored, word[31:0]);
        check_field("has_winner", DATA_W'(want.has_winner), DATA_W'(word[32]));
        check_field("winner_session", DATA_W'(want.winner), DATA_W'(word[36:33]));
        check_field("applied_period", want.applied, word[68:37]);
        check_field("period_changed", DATA_W'(want.changed), DATA_W'(word[69]));
    endtask

    // Configuration writes, requests and results, all sampled at the rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_count_q = '0;
            default_period_q = '0;
            applied_period_q = '0;
            for (int r = 0; r < RANGES; r++)
            begin
                range_low_q[r] = '0;
                range_high_q[r] = '0;
            end
            for (int s = 0; s < SESSIONS; s++)
            begin
                entry_present_q[s] = 1'b0;
                entry_period_q[s] = '0;
            end
            pending_results.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_RANGE_COUNT)
                    range_count_q = cfg_wdata[1:0];
                if (cfg_addr == CFG_DEFAULT_PERIOD)
                    default_period_q = cfg_wdata;
                for (int r = 0; r < RANGES; r++)
                begin
                    if (cfg_addr == range_low_addr(r))
                        range_low_q[r] = cfg_wdata;
                    if (cfg_addr == range_high_addr(r))
                        range_high_q[r] = cfg_wdata;
                end
            end
            if (s_tvalid && s_tready)
                pending_results.insert(pending_results.size(),
                                       work_out_request(s_tuser, s_tdata[3:0],
                                                        s_tdata[35:4]));
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            outstanding = pending_results.size();
        end
    end

endmodule

### tb/sv/testbench.sv
// Top of the sample interval arbiter testbench: clock, reset, configuration and
// request stimulus, result back-pressure and the verdict. Depends on sia_pkg,
// sia_checker and sample_interval_arbiter_unit.
`timescale 1ns / 100ps

module testbench
    import sia_pkg::*;
();

    localparam int SESSIONS = 16;
    localparam int RANGES = 3;
    // Worst request time, built from the number of ranges and of sessions.
    localparam int SCAN_CYCLES = SESSIONS + RANGES + 3;
    localparam int SETTLE_CYCLES = SCAN_CYCLES + 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS = 118;
    localparam int LONG_HOLD = 400;
    localparam int HOLD_AFTER_WORDS = 150;
    // About 1200 words, each with its block time, idle gaps and stalls; the limit
    // allows about three times the expected run.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [KIND_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    int errors;
    int outstanding;
    int cycle_count = 0;
    int words_sent = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    // Stimulus copy of the configuration, used to aim requests at the ranges.
    logic [1:0]        cur_count;
    logic [DATA_W-1:0] cur_low [RANGES];
    logic [DATA_W-1:0] cur_high [RANGES];
    logic [DATA_W-1:0] cur_default;

    sample_interval_arbiter_unit #(
        .SESSIONS (SESSIONS),
        .RANGES   (RANGES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    sia_checker #(
        .SESSIONS (SESSIONS),
        .RANGES   (RANGES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    function automatic logic [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'd1;
            2: return ERR_LIMIT;
            3: return ERR_LIMIT + 32'd1;
            4: return 32'hffff_fffe;
            default: return '1;
        endcase
    endfunction

    // Requested interval aimed at the ranges, their bounds and the gaps between.
    function automatic logic [DATA_W-1:0] pick_interval();
        int                r;
        logic [DATA_W-1:0] edge_val;
        logic [DATA_W:0]   sum;
        r = $urandom_range(0, RANGES - 1);
        edge_val = $urandom_range(0, 1) ? cur_low[r] : cur_high[r];
        sum = {1'b0, cur_high[r]} + {1'b0, cur_low[(r + 1) % RANGES]};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3, 4: return $urandom_range(cur_high[r], cur_low[r]);
            5, 6: return edge_val + $urandom_range(0, 8) - 4;
            // Midway between two ranges gives equal distances.
            7: return sum[DATA_W:1];
            8: return $urandom_range(1, 1000);
            // Distances right around the limit.
            default: return edge_val + ERR_LIMIT + $urandom_range(0, 2) - 1;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return KIND_SET;
        else if (roll < 75)
            return KIND_REMOVE;
        else if (roll < 93)
            return KIND_DEFAULT;
        return KIND_UNKNOWN;
    endfunction

    // Writes every register from the stimulus copy, then drops the enable.
    task automatic apply_setting();
        cfg_we = 1'b1;
        cfg_addr = CFG_RANGE_COUNT;
        cfg_wdata = CFG_DATA_W'(cur_count);
        @(negedge clk);
        for (int r = 0; r < RANGES; r++)
        begin
            cfg_addr = range_low_addr(r);
            cfg_wdata = cur_low[r];
            @(negedge clk);
            cfg_addr = range_high_addr(r);
            cfg_wdata = cur_high[r];
            @(negedge clk);
        end
        cfg_addr = CFG_DEFAULT_PERIOD;
        cfg_wdata = cur_default;
        @(negedge clk);
        cfg_we = 1'b0;
        @(negedge clk);
    endtask

    // Random setting; phase 0 forces extreme bounds, phase 1 no ranges.
    task automatic random_setting(input int phase);
        int                style;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        style = (phase == 0) ? 2 : (phase == 2) ? 0 : $urandom_range(0, 3);
        cur_count = (phase == 0 || phase == 2) ? 2'd3 : (phase == 1) ? 2'd0
                                                 : 2'($urandom_range(0, 3));
        for (int r = 0; r < RANGES; r++)
        begin
            case (style)
                0:
                begin
                    a = $urandom_range(1, 100000);
                    b = $urandom_range(1, 100000);
                end
                1:
                begin
                    a = $urandom;
                    b = $urandom;
                end
                2:
                begin
                    a = pick_extreme();
                    b = pick_extreme();
                end
                default:
                begin
                    // Inverted range: low above high.
                    a = $urandom;
                    b = $urandom;
                    {a, b} = (a > b) ? {b, a} : {a, b};
                    {a, b} = {b, a};
                end
            endcase
            cur_low[r] = (style == 3 || a <= b) ? a : b;
            cur_high[r] = (style == 3 || a <= b) ? b : a;
        end
        case ($urandom_range(0, 4))
            0: cur_default = '0;
            1: cur_default = $urandom_range(1, 100000);
            2: cur_default = $urandom;
            3: cur_default = '1;
            default: cur_default = $urandom_range(cur_high[0], cur_low[0]);
        endcase
        if (phase == 0)
            cur_default = '1;
        else if (phase == 1)
            cur_default = '0;
        apply_setting();
    endtask

    // Offers one request word and holds it until taken; returns at a falling edge.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [SESS_FIELD_W-1:0] sess,
                                input logic [DATA_W-1:0] period);
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = {4'b0, period, sess};
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic idle_after();
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic request(input logic [KIND_W-1:0] kind, input int sess,
                           input logic [DATA_W-1:0] period);
        send_request(kind, SESS_FIELD_W'(sess), period);
        idle_after();
    endtask

    // Stops offering and waits until every result word has come.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Result side: random stalls, one long hold-off after HOLD_AFTER_WORDS requests.
    initial
    begin
        int  stall_left;
        bit  hold_done;
        m_tready = 1'b0;
        stall_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && words_sent >= HOLD_AFTER_WORDS)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Reset, directed requests, random phases and the verdict.
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_SET;
        cur_count = '0;
        cur_default = '0;
        for (int r = 0; r < RANGES; r++)
        begin
            cur_low[r] = '0;
            cur_high[r] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // With no ranges a request snaps to zero; no default means the
        // default request is ignored.
        request(KIND_SET, 3, 32'd1234);
        request(KIND_DEFAULT, 4, '0);
        request(KIND_REMOVE, 3, '0);
        wait_idle();

        // Three ordered ranges and a default between the first two.
        cur_count = 2'd3;
        cur_low[0] = 32'd100;
        cur_high[0] = 32'd200;
        cur_low[1] = 32'd1000;
        cur_high[1] = 32'd2000;
        cur_low[2] = 32'd50000;
        cur_high[2] = 32'd60000;
        cur_default = 32'd500;
        apply_setting();
        request(KIND_SET, 0, 32'd150);         // inside a range
        request(KIND_SET, 1, 32'd250);         // above a range
        request(KIND_SET, 2, '0);              // zero stays zero
        request(KIND_SET, 3, '1);              // too far from every bound
        request(KIND_SET, 15, 32'd600);        // equal distance, earlier range
        request(KIND_SET, 14, 32'd700);
        request(KIND_SET, 13, 32'd30000);
        request(KIND_DEFAULT, 4, '0);
        request(KIND_SET, 5, 32'd150);         // tie with session 0
        request(KIND_REMOVE, 0, '0);
        request(KIND_REMOVE, 9, '0);           // absent session
        request(KIND_UNKNOWN, 6, 32'd777);
        request(KIND_REMOVE, 1, '0);
        request(KIND_REMOVE, 4, '0);
        request(KIND_REMOVE, 5, '0);
        request(KIND_REMOVE, 13, '0);
        request(KIND_REMOVE, 14, '0);
        request(KIND_REMOVE, 15, '0);          // only zero entries left
        request(KIND_SET, 0, '1);
        request(KIND_REMOVE, 2, '0);
        request(KIND_REMOVE, 3, '0);
        request(KIND_REMOVE, 0, '0);           // table now empty
        wait_idle();

        // Random phases, each under its own setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_setting(phase);
            tx_steady = (phase % 4 == 1);
            rx_steady = (phase % 4 == 1);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 1))
                    request(pick_kind(), $urandom_range(0, 3), pick_interval());
                else
                    request(pick_kind(), $urandom_range(0, SESSIONS - 1), pick_interval());
            end
            wait_idle();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hw/rtl/sia_pkg.sv
hw/rtl/sia_cell.sv
hw/rtl/sia_snap.sv
hw/rtl/sample_interval_arbiter_unit.sv
tb/sv/sia_checker.sv
tb/sv/testbench.sv
